>>> hdl/cae_pkg.sv
`timescale 1ns / 1ps
// cae_pkg: opcodes, condition codes and word types of the ALU execute unit.
// No dependencies; imported by cae_alu and cpu_alu_execute_unit.
package cae_pkg;

	typedef enum logic [3:0] {
		OP_LOAD  = 4'd0,
		OP_STORE = 4'd1,
		OP_ADD   = 4'd2,
		OP_SUB   = 4'd3,
		OP_SHL   = 4'd4,
		OP_SHR   = 4'd5,
		OP_ROL   = 4'd6,
		OP_ROR   = 4'd7,
		OP_CLC   = 4'd8,
		OP_INC   = 4'd9,
		OP_DEC   = 4'd10,
		OP_CMP   = 4'd11,
		OP_HALT  = 4'd12,
		OP_JUMP  = 4'd13,
		OP_BRIF  = 4'd14,
		OP_BRNOT = 4'd15
	} op_t;

	localparam logic [2:0] COND_Z = 3'd0;
	localparam logic [2:0] COND_N = 3'd1;
	localparam logic [2:0] COND_C = 3'd2;
	localparam logic [2:0] COND_O = 3'd3;
	localparam logic [2:0] COND_L = 3'd4;
	localparam logic [2:0] COND_G = 3'd5;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	typedef struct packed {
		logic l;
		logic g;
		logic n;
		logic z;
		logic o;
		logic c;
	} flags_t;

	typedef struct packed {
		op_t        op;
		logic       mode;
		logic [1:0] dest_reg;
		logic [1:0] src_reg;
		logic [7:0] operand;
		logic [2:0] cond;
	} instr_t;

	typedef struct packed {
		logic [7:0] result_value;
		logic       store_to_memory;
		flags_t     flags;
		logic       branch_taken;
		logic       halted;
	} result_t;

	typedef struct packed {
		logic       en;
		logic [7:0] value;
	} wback_t;

endpackage

>>> hdl/cae_alu.sv
`timescale 1ns / 1ps
// cae_alu: combinational execute of one instruction against the current flags.
// Depends on cae_pkg.
module cae_alu import cae_pkg::*; (
	input  instr_t     instr,
	input  logic [7:0] rd_a,
	input  logic [7:0] rd_b,
	input  flags_t     flags,
	input  logic       halt,
	output result_t    res,
	output wback_t     wb
);

	logic [7:0] b;
	logic [7:0] x;
	logic [7:0] inv;
	logic [7:0] diff;
	logic [8:0] sum;
	logic       f;

	assign b    = instr.mode ? rd_b : instr.operand;
	assign x    = instr.mode ? rd_a : instr.operand;
	assign inv  = (instr.op == OP_SUB) ? ~b : b;
	assign sum  = {1'b0, rd_a} + {1'b0, inv} + {8'd0, flags.c};
	assign diff = rd_a - b;

	always_comb begin
		case (instr.cond)
			COND_Z:  f = flags.z;
			COND_N:  f = flags.n;
			COND_C:  f = flags.c;
			COND_O:  f = flags.o;
			COND_L:  f = flags.l;
			COND_G:  f = flags.g;
			default: f = 1'b0;
		endcase
	end

	always_comb begin
		res.result_value    = 8'd0;
		res.store_to_memory = 1'b0;
		res.flags           = flags;
		res.branch_taken    = 1'b0;
		res.halted          = halt;
		wb.en               = 1'b0;
		wb.value            = 8'd0;
		if (!halt) begin
			case (instr.op)
				OP_LOAD: begin
					res.result_value = b;
					wb.en            = 1'b1;
				end
				OP_STORE: begin
					if (!instr.mode) begin
						res.result_value    = rd_a;
						res.store_to_memory = 1'b1;
					end
				end
				OP_ADD, OP_SUB: begin
					res.result_value = sum[7:0];
					res.flags.c      = sum[8];
					res.flags.o      = (sum[7] ^ rd_a[7]) & (sum[7] ^ inv[7]);
					res.flags.z      = (sum[7:0] == 8'd0);
					res.flags.n      = sum[7];
					wb.en            = 1'b1;
				end
				OP_SHL, OP_SHR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
					case (instr.op)
						OP_SHL: begin
							res.flags.c      = x[7];
							res.result_value = {x[6:0], 1'b0};
						end
						OP_SHR: begin
							res.flags.c      = x[0];
							res.result_value = {1'b0, x[7:1]};
						end
						OP_ROL: begin
							res.flags.c      = x[7];
							res.result_value = {x[6:0], x[7]};
						end
						OP_ROR: begin
							res.flags.c      = x[0];
							res.result_value = {x[0], x[7:1]};
						end
						OP_INC:  res.result_value = x + 8'd1;
						default: res.result_value = x - 8'd1;
					endcase
					res.flags.z = (res.result_value == 8'd0);
					res.flags.n = res.result_value[7];
					if (instr.mode)
						wb.en = 1'b1;
					else
						res.store_to_memory = 1'b1;
				end
				OP_CLC:  res.flags.c = 1'b0;
				OP_CMP: begin
					res.flags.z = (rd_a == b);
					res.flags.n = diff[7];
					res.flags.g = (rd_a > b);
					res.flags.l = (rd_a < b);
				end
				OP_HALT: res.halted       = 1'b1;
				OP_JUMP: res.branch_taken = 1'b1;
				OP_BRIF: res.branch_taken = f;
				OP_BRNOT: res.branch_taken = !f;
				default: res.branch_taken = 1'b0;
			endcase
			wb.value = res.result_value;
		end
	end

endmodule

>>> hdl/cpu_alu_execute_unit.sv
`timescale 1ns / 1ps
// cpu_alu_execute_unit: 8-bit execute stage with register file, flags and halt mark.
// Depends on cae_pkg and cae_alu.
// Pipeline: an accepted word enters the input register, its result the result reg.
// Throughput: one word per cycle unless m_axis_tready stalls the output; the
// register file and flags update as a word leaves the input register, so the next
// word sees them at once.
// Reset (arst_n low, async): registers, flags, halt mark and valid bits clear to zero.
module cpu_alu_execute_unit import cae_pkg::*; #(
	parameter int NUM_REGS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// op[3:0], dest_reg[5:4], src_reg[7:6], operand[15:8], cond[18:16], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode[0]
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// result_value[7:0], carry[8], overflow[9], zero[10], negative[11],
	// greater[12], less[13], branch_taken[14], halted[15]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// store_to_memory[0]
	output logic                   m_axis_tuser
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	instr_t     in_instr;
	instr_t     instr_s1;
	logic       v_s1;
	result_t    res_s2;
	logic       v_s2;
	logic       adv;
	logic [7:0] regs_q [NUM_REGS];
	flags_t     flags_q;
	logic       halt_q;
	logic       d_ok;
	logic       s_ok;
	logic [7:0] rd_a;
	logic [7:0] rd_b;
	result_t    res;
	wback_t     wb;

	always_comb begin
		in_instr.op       = op_t'(s_axis_tdata[3:0]);
		in_instr.mode     = s_axis_tuser;
		in_instr.dest_reg = s_axis_tdata[5:4];
		in_instr.src_reg  = s_axis_tdata[7:6];
		in_instr.operand  = s_axis_tdata[15:8];
		in_instr.cond     = s_axis_tdata[18:16];
	end

	assign adv           = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			instr_s1 <= in_instr;
	end

	assign d_ok = (32'(instr_s1.dest_reg) < NUM_REGS);
	assign s_ok = (32'(instr_s1.src_reg) < NUM_REGS);
	assign rd_a = d_ok ? regs_q[IDX_W'(instr_s1.dest_reg)] : 8'd0;
	assign rd_b = s_ok ? regs_q[IDX_W'(instr_s1.src_reg)] : 8'd0;

	cae_alu u_alu (
		.instr (instr_s1),
		.rd_a  (rd_a),
		.rd_b  (rd_b),
		.flags (flags_q),
		.halt  (halt_q),
		.res   (res),
		.wb    (wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				regs_q[i] <= 8'd0;
			flags_q <= '0;
			halt_q  <= 1'b0;
		end else if (adv) begin
			if (wb.en && d_ok)
				regs_q[IDX_W'(instr_s1.dest_reg)] <= wb.value;
			flags_q <= res.flags;
			halt_q  <= res.halted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tuser  = res_s2.store_to_memory;
	assign m_axis_tdata  = {res_s2.halted, res_s2.branch_taken,
		res_s2.flags.l, res_s2.flags.g, res_s2.flags.n, res_s2.flags.z,
		res_s2.flags.o, res_s2.flags.c, res_s2.result_value};

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt mark cleared without reset");

	a_halted_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[15] |->
			!m_axis_tuser && !m_axis_tdata[14] && (m_axis_tdata[7:0] == 8'd0))
		else $error("halted result carries a store, branch or value");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(flags_q) && $stable(halt_q))
		else $error("flags changed with no word executed");

endmodule

>>> dv/cpu_alu_execute_unit_test.sv
`timescale 1ns / 1ps
// cpu_alu_execute_unit_test: self-checking bench for the 8-bit ALU execute unit.
// Tracks registers, flags and halt mark per accepted word and checks every result word.
// Depends on cae_pkg and cpu_alu_execute_unit.
module cpu_alu_execute_unit_test;
	import cae_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_PRINTS  = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	logic [7:0] regs [4] = '{default: 8'h00};
	flags_t     cur_flags = '0;
	logic       halt_seen = 1'b0;
	result_t    expected_results [$];
	int         mismatches = 0;
	int         words_seen = 0;
	int         cycles = 0;
	bit         no_idle = 1'b0;

	cpu_alu_execute_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending", cycles,
				expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("ERROR word %0d %s: got %0h expected %0h", words_seen, field, got, want);
	endtask

	// Updates the tracked state and queues the result word for one instruction.
	task automatic execute_instr(input instr_t w);
		result_t    r;
		logic [7:0] a, b, x, inv;
		logic [8:0] sum;
		logic       f;
		r = '0;
		if (!halt_seen) begin
			a = regs[w.dest_reg];
			b = w.mode ? regs[w.src_reg] : w.operand;
			x = w.mode ? a : w.operand;
			case (w.op)
			OP_LOAD: begin
				r.result_value = b;
				regs[w.dest_reg] = b;
			end
			OP_STORE: begin
				if (!w.mode) begin
					r.result_value = a;
					r.store_to_memory = 1'b1;
				end
			end
			OP_ADD, OP_SUB: begin
				inv = (w.op == OP_SUB) ? ~b : b;
				sum = {1'b0, a} + {1'b0, inv} + {8'h00, cur_flags.c};
				r.result_value = sum[7:0];
				cur_flags.c = sum[8];
				cur_flags.o = (sum[7] ^ a[7]) & (sum[7] ^ inv[7]);
				cur_flags.z = (sum[7:0] == 8'h00);
				cur_flags.n = sum[7];
				regs[w.dest_reg] = sum[7:0];
			end
			OP_SHL, OP_SHR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
				case (w.op)
				OP_SHL: begin
					cur_flags.c = x[7];
					r.result_value = {x[6:0], 1'b0};
				end
				OP_SHR: begin
					cur_flags.c = x[0];
					r.result_value = {1'b0, x[7:1]};
				end
				OP_ROL: begin
					cur_flags.c = x[7];
					r.result_value = {x[6:0], x[7]};
				end
				OP_ROR: begin
					cur_flags.c = x[0];
					r.result_value = {x[0], x[7:1]};
				end
				OP_INC: r.result_value = x + 8'h01;
				default: r.result_value = x - 8'h01;
				endcase
				cur_flags.z = (r.result_value == 8'h00);
				cur_flags.n = r.result_value[7];
				if (w.mode)
					regs[w.dest_reg] = r.result_value;
				else
					r.store_to_memory = 1'b1;
			end
			OP_CLC: cur_flags.c = 1'b0;
			OP_CMP: begin
				inv = a - b;
				cur_flags.z = (a == b);
				cur_flags.n = inv[7];
				cur_flags.g = (a > b);
				cur_flags.l = (a < b);
			end
			OP_HALT: halt_seen = 1'b1;
			OP_JUMP: r.branch_taken = 1'b1;
			default: begin
				case (w.cond)
				COND_Z: f = cur_flags.z;
				COND_N: f = cur_flags.n;
				COND_C: f = cur_flags.c;
				COND_O: f = cur_flags.o;
				COND_L: f = cur_flags.l;
				COND_G: f = cur_flags.g;
				default: f = 1'b0;
				endcase
				r.branch_taken = (w.op == OP_BRIF) ? f : !f;
			end
			endcase
		end
		r.flags = cur_flags;
		r.halted = halt_seen;
		expected_results.push_back(r);
	endtask

	task automatic send_instr(input instr_t w);
		while (!no_idle && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, w.cond, w.operand, w.src_reg, w.dest_reg, w.op};
		s_axis_tuser  <= w.mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		execute_instr(w);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic check_result();
		result_t got, want;
		got.result_value    = m_axis_tdata[7:0];
		got.store_to_memory = m_axis_tuser;
		got.flags.c         = m_axis_tdata[8];
		got.flags.o         = m_axis_tdata[9];
		got.flags.z         = m_axis_tdata[10];
		got.flags.n         = m_axis_tdata[11];
		got.flags.g         = m_axis_tdata[12];
		got.flags.l         = m_axis_tdata[13];
		got.branch_taken    = m_axis_tdata[14];
		got.halted          = m_axis_tdata[15];
		words_seen++;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result word", 32'(m_axis_tdata), 32'd0);
			return;
		end
		want = expected_results.pop_front();
		if (got.result_value !== want.result_value)
			report_mismatch("result_value", 32'(got.result_value),
				32'(want.result_value));
		if (got.store_to_memory !== want.store_to_memory)
			report_mismatch("store_to_memory", 32'(got.store_to_memory),
				32'(want.store_to_memory));
		if (got.flags.c !== want.flags.c)
			report_mismatch("carry", 32'(got.flags.c), 32'(want.flags.c));
		if (got.flags.o !== want.flags.o)
			report_mismatch("overflow", 32'(got.flags.o), 32'(want.flags.o));
		if (got.flags.z !== want.flags.z)
			report_mismatch("zero", 32'(got.flags.z), 32'(want.flags.z));
		if (got.flags.n !== want.flags.n)
			report_mismatch("negative", 32'(got.flags.n), 32'(want.flags.n));
		if (got.flags.g !== want.flags.g)
			report_mismatch("greater", 32'(got.flags.g), 32'(want.flags.g));
		if (got.flags.l !== want.flags.l)
			report_mismatch("less", 32'(got.flags.l), 32'(want.flags.l));
		if (got.branch_taken !== want.branch_taken)
			report_mismatch("branch_taken", 32'(got.branch_taken),
				32'(want.branch_taken));
		if (got.halted !== want.halted)
			report_mismatch("halted", 32'(got.halted), 32'(want.halted));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
		end
	end

	function automatic instr_t mk(input op_t op, input logic mode, input logic [1:0] dest,
		input logic [1:0] src, input logic [7:0] val, input logic [2:0] cnd);
		instr_t w;
		w.op       = op;
		w.mode     = mode;
		w.dest_reg = dest;
		w.src_reg  = src;
		w.operand  = val;
		w.cond     = cnd;
		return w;
	endfunction

	function automatic instr_t random_instr(input bit with_halt);
		instr_t     w;
		logic [7:0] corners [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		do w.op = op_t'(4'($urandom_range(15))); while (!with_halt && w.op == OP_HALT);
		w.mode     = 1'($urandom_range(1));
		w.dest_reg = 2'($urandom_range(3));
		w.src_reg  = 2'($urandom_range(3));
		w.operand  = ($urandom_range(3) == 0) ? corners[3'($urandom_range(5))]
			: 8'($urandom_range(255));
		w.cond     = 3'($urandom_range(7));
		return w;
	endfunction

	task automatic test_load_store();
		send_instr(mk(OP_LOAD, 1'b0, 2'd0, 2'd0, 8'hFF, 3'd0));
		send_instr(mk(OP_LOAD, 1'b0, 2'd1, 2'd0, 8'h01, 3'd7));
		send_instr(mk(OP_LOAD, 1'b1, 2'd2, 2'd0, 8'h00, 3'd0));
		send_instr(mk(OP_STORE, 1'b0, 2'd2, 2'd3, 8'hAA, 3'd0));
		// store in register mode does nothing
		send_instr(mk(OP_STORE, 1'b1, 2'd0, 2'd1, 8'h55, 3'd0));
	endtask

	task automatic test_add_sub();
		send_instr(mk(OP_CLC, 1'b0, 2'd0, 2'd0, 8'h00, 3'd0));
		send_instr(mk(OP_ADD, 1'b1, 2'd0, 2'd1, 8'h00, 3'd0));
		// carry in set: 0 + 7F + 1 overflows to 80
		send_instr(mk(OP_ADD, 1'b0, 2'd3, 2'd0, 8'h7F, 3'd0));
		send_instr(mk(OP_SUB, 1'b0, 2'd3, 2'd0, 8'h01, 3'd0));
	endtask

	task automatic test_shift_rotate();
		send_instr(mk(OP_SHL, 1'b0, 2'd0, 2'd0, 8'h80, 3'd0));
		send_instr(mk(OP_SHR, 1'b1, 2'd1, 2'd0, 8'h00, 3'd0));
		send_instr(mk(OP_ROL, 1'b0, 2'd0, 2'd0, 8'h81, 3'd0));
		send_instr(mk(OP_ROR, 1'b1, 2'd2, 2'd0, 8'h00, 3'd0));
		send_instr(mk(OP_INC, 1'b0, 2'd0, 2'd0, 8'hFF, 3'd0));
		send_instr(mk(OP_DEC, 1'b1, 2'd1, 2'd0, 8'h00, 3'd0));
	endtask

	task automatic test_compare_branch();
		send_instr(mk(OP_CMP, 1'b0, 2'd2, 2'd0, 8'hFF, 3'd0));
		send_instr(mk(OP_CMP, 1'b0, 2'd1, 2'd0, 8'h00, 3'd0));
		send_instr(mk(OP_CMP, 1'b1, 2'd3, 2'd2, 8'h00, 3'd0));
		send_instr(mk(OP_JUMP, 1'b0, 2'd0, 2'd0, 8'h00, 3'd0));
		// conditions 6 and 7 test a flag that reads as zero
		for (int k = 0; k < 8; k++)
			send_instr(mk((k % 2) ? OP_BRNOT : OP_BRIF, 1'b0, 2'd0, 2'd0, 8'h00, 3'(k)));
	endtask

	task automatic test_random_traffic();
		repeat (600) send_instr(random_instr(1'b0));
		wait_for_results();
		no_idle = 1'b1;
		repeat (400) send_instr(random_instr(1'b0));
		no_idle = 1'b0;
		repeat (700) send_instr(random_instr(1'b0));
	endtask

	// halt holds state until reset, so it runs last
	task automatic test_halt();
		send_instr(mk(OP_HALT, 1'b0, 2'd0, 2'd0, 8'h00, 3'd0));
		repeat (20) send_instr(random_instr(1'b1));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_store();
		test_add_sub();
		test_shift_rotate();
		test_compare_branch();
		test_random_traffic();
		test_halt();
		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
